### hw/rtl/e3ws_pkg.sv
// ----------------------------------------------------------------------------
// e3ws_pkg
// Shared constants and register codes for the 3x3 window-sum extreme search.
// ----------------------------------------------------------------------------
package e3ws_pkg;

    localparam int MAX_COLS_DEF     = 1024;
    localparam int ELEMENT_BITS_DEF = 8;

    localparam int ROW_W      = 12;   // frame_rows, row counter, row outputs
    localparam int FCOL_W     = 11;   // frame_cols register
    localparam int OCOL_W     = 10;   // column outputs
    localparam int OSUM_W     = 12;   // sum outputs
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int MIN_START  = 4000;
    localparam int FRAME_MIN  = 3;

    typedef enum logic [0:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } reg_index_t;

endpackage

### hw/rtl/extreme_3x3_window_sum_search_core.sv
// ----------------------------------------------------------------------------
// extreme_3x3_window_sum_search_core
// Streams a matrix in raster order, forms every full 3x3 window sum from a
// combined two-row line store and two column-sum registers, and reports the
// largest and smallest sum with their top-left positions once per frame.
//
//   channel  direction  signals
//   s_       in         s_valid, s_ready, s_element_value
//   m_       out        m_valid, m_ready, m_max_sum/row/col, m_min_sum/row/col
//   apb      in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request per cycle while s_ready is high; three-stage pipeline: address
// and read of the combined line store, column and window sum with write-back,
// tracker update. A frame result loads as its last request leaves stage 2.
// Reset clears control state only; line store words read in a frame's first
// two rows never reach a window sum, so no clearing pass is run.
// s_ready drops only for a frame's last request while the result register
// still holds an untaken result.
// ----------------------------------------------------------------------------
module extreme_3x3_window_sum_search_core
    import e3ws_pkg::*;
#(
    parameter int MAX_COLS     = MAX_COLS_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ELEMENT_BITS-1:0] s_element_value,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OSUM_W-1:0]       m_max_sum,
    output logic [ROW_W-1:0]        m_max_row,
    output logic [OCOL_W-1:0]       m_max_col,
    output logic [OSUM_W-1:0]       m_min_sum,
    output logic [ROW_W-1:0]        m_min_row,
    output logic [OCOL_W-1:0]       m_min_col,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EB   = ELEMENT_BITS;
    localparam int CSW  = EB + 2;
    localparam int SW   = EB + 4;
    localparam int BW   = (SW > OSUM_W) ? SW : OSUM_W;
    localparam int MW   = 2 * EB;
    localparam logic [12:0] MAXC_13   = 13'(MAX_COLS);
    localparam logic [BW-1:0] MIN_INIT = BW'(MIN_START);

    // configuration
    logic [ROW_W-1:0]  frame_rows_reg;
    logic [FCOL_W-1:0] frame_cols_reg;
    logic [ROW_W-1:0]  last_row_reg, last_row_next;
    logic [CW-1:0]     last_col_reg, last_col_next;
    logic              cfg_wr;
    logic [ROW_W-1:0]  fr_new;
    logic [FCOL_W-1:0] fc_new;

    // stage 0
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic             in_fire;
    logic             in_last;
    logic             in_win;

    // stage 1
    logic             v1_reg;
    logic [CW-1:0]    c1_reg;
    logic [EB-1:0]    x1_reg;
    logic             win1_reg, last1_reg;
    logic [ROW_W-1:0] pr1_reg;
    logic [CW-1:0]    pc1_reg;
    logic [MW-1:0]    rd_data_reg;
    logic [MW-1:0]    line_mem [MAX_COLS];
    logic [EB-1:0]    upper_rd, lower_rd;
    logic [CSW-1:0]   colsum;
    logic [CSW-1:0]   csp0_reg, csp1_reg;
    logic [SW-1:0]    sum1;

    // stage 2
    logic             v2_reg;
    logic [SW-1:0]    sum2_reg;
    logic             win2_reg, last2_reg;
    logic [ROW_W-1:0] pr2_reg;
    logic [CW-1:0]    pc2_reg;

    // trackers
    logic [BW-1:0]    best_max_reg, best_max_next;
    logic [BW-1:0]    best_min_reg, best_min_next;
    logic [ROW_W-1:0] max_row_reg, max_row_next, min_row_reg, min_row_next;
    logic [CW-1:0]    max_col_reg, max_col_next, min_col_reg, min_col_next;
    logic [BW-1:0]    sum2_ext;
    logic             out_load;

    // result register
    logic              m_valid_reg;
    logic [OSUM_W-1:0] o_max_sum_reg, o_min_sum_reg;
    logic [ROW_W-1:0]  o_max_row_reg, o_min_row_reg;
    logic [OCOL_W-1:0] o_max_col_reg, o_min_col_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign fr_new = pwdata[ROW_W-1:0];
    assign fc_new = pwdata[FCOL_W-1:0];

    always_comb begin
        case (reg_index_t'(paddr[2]))
            REG_FRAME_ROWS: prdata = APB_DW'(frame_rows_reg);
            REG_FRAME_COLS: prdata = APB_DW'(frame_cols_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (fr_new < ROW_W'(FRAME_MIN)) begin
            last_row_next = ROW_W'(FRAME_MIN - 1);
        end else begin
            last_row_next = fr_new - ROW_W'(1);
        end
        if (fc_new < FCOL_W'(FRAME_MIN)) begin
            last_col_next = CW'(FRAME_MIN - 1);
        end else if (13'(fc_new) > MAXC_13) begin
            last_col_next = CW'(MAX_COLS - 1);
        end else begin
            last_col_next = CW'(fc_new - FCOL_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= ROW_W'(FRAME_MIN);
            frame_cols_reg <= FCOL_W'(FRAME_MIN);
            last_row_reg   <= ROW_W'(FRAME_MIN - 1);
            last_col_reg   <= CW'(FRAME_MIN - 1);
        end else if (cfg_wr) begin
            case (reg_index_t'(paddr[2]))
                REG_FRAME_ROWS: begin
                    frame_rows_reg <= fr_new;
                    last_row_reg   <= last_row_next;
                end
                REG_FRAME_COLS: begin
                    frame_cols_reg <= fc_new;
                    last_col_reg   <= last_col_next;
                end
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: counters and store read ----------------
    assign in_last = (col_reg == last_col_reg) && (row_reg == last_row_reg);
    assign in_win  = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
    assign s_ready = !(in_last && m_valid_reg && !m_ready);
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (cfg_wr) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (in_fire) begin
            if (col_reg == last_col_reg) begin
                col_reg <= '0;
                row_reg <= (row_reg == last_row_reg) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // combined line store: {upper, lower} per column
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            line_mem[c1_reg] <= {lower_rd, x1_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            c1_reg    <= col_reg;
            x1_reg    <= s_element_value;
            win1_reg  <= in_win;
            last1_reg <= in_last;
            pr1_reg   <= row_reg - ROW_W'(2);
            pc1_reg   <= col_reg - CW'(2);
        end
    end

    // ---------------- stage 1: column and window sums ----------------
    assign upper_rd = rd_data_reg[MW-1:EB];
    assign lower_rd = rd_data_reg[EB-1:0];
    assign colsum   = CSW'(upper_rd) + CSW'(lower_rd) + CSW'(x1_reg);
    assign sum1     = SW'(colsum) + SW'(csp0_reg) + SW'(csp1_reg);

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            csp0_reg  <= colsum;
            csp1_reg  <= csp0_reg;
            sum2_reg  <= sum1;
            win2_reg  <= win1_reg;
            last2_reg <= last1_reg;
            pr2_reg   <= pr1_reg;
            pc2_reg   <= pc1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
    end

    // ---------------- stage 2: tracker update ----------------
    assign sum2_ext = BW'(sum2_reg);
    assign out_load = v2_reg && last2_reg;

    always_comb begin
        best_max_next = best_max_reg;
        max_row_next  = max_row_reg;
        max_col_next  = max_col_reg;
        best_min_next = best_min_reg;
        min_row_next  = min_row_reg;
        min_col_next  = min_col_reg;
        if (v2_reg && win2_reg) begin
            if (sum2_ext >= best_max_reg) begin
                best_max_next = sum2_ext;
                max_row_next  = pr2_reg;
                max_col_next  = pc2_reg;
            end
            if (sum2_ext <= best_min_reg) begin
                best_min_next = sum2_ext;
                min_row_next  = pr2_reg;
                min_col_next  = pc2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr || out_load) begin
            best_max_reg <= '0;
            best_min_reg <= MIN_INIT;
            max_row_reg  <= '0;
            max_col_reg  <= '0;
            min_row_reg  <= '0;
            min_col_reg  <= '0;
        end else begin
            best_max_reg <= best_max_next;
            best_min_reg <= best_min_next;
            max_row_reg  <= max_row_next;
            max_col_reg  <= max_col_next;
            min_row_reg  <= min_row_next;
            min_col_reg  <= min_col_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_max_sum_reg <= OSUM_W'(best_max_next);
            o_max_row_reg <= max_row_next;
            o_max_col_reg <= OCOL_W'(max_col_next);
            o_min_sum_reg <= OSUM_W'(best_min_next);
            o_min_row_reg <= min_row_next;
            o_min_col_reg <= OCOL_W'(min_col_next);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_max_sum = o_max_sum_reg;
    assign m_max_row = o_max_row_reg;
    assign m_max_col = o_max_col_reg;
    assign m_min_sum = o_min_sum_reg;
    assign m_min_row = o_min_row_reg;
    assign m_min_col = o_min_col_reg;

    // ---------------- assertions ----------------
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input stalled with empty result register");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col_reg)
        else $error("column counter past frame width");

    a_trackers_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (best_max_reg == '0) && (best_min_reg == MIN_INIT))
        else $error("trackers not cleared after result");

    a_pipe_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> v1_reg ##1 v2_reg)
        else $error("pipeline valid lost");

endmodule

### bench/tb_extreme_3x3_window_sum_search_core.sv
// ----------------------------------------------------------------------------
// tb_extreme_3x3_window_sum_search_core
// Self-checking bench for the 3x3 window-sum extreme search core. A clocked
// driver feeds element requests from a queue. A clocked monitor predicts the
// per-frame extremes and their positions, and checks every frame result field
// by field. Frame size registers are programmed over APB between phases. The
// stimulus covers the register clamps and masks, ties and aborted frames.
// Both sides idle at random, and one long output stall forces input
// backpressure.
// ----------------------------------------------------------------------------
module tb_extreme_3x3_window_sum_search_core;
    import e3ws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EL_W            = ELEMENT_BITS_DEF;
    localparam int CSUM_W          = ELEMENT_BITS_DEF + 2;
    localparam int LONG_STALL      = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_REQUESTS = 1050;
    localparam int RANDOM_RESULTS  = 20;

    typedef enum int {
        FILL_RANDOM,
        FILL_CONST,
        FILL_BINARY,
        FILL_LOW,
        FILL_EDGES,
        FILL_EDGES_INV
    } frame_fill_t;

    typedef struct packed {
        logic [OSUM_W-1:0] max_sum;
        logic [ROW_W-1:0]  max_row;
        logic [OCOL_W-1:0] max_col;
        logic [OSUM_W-1:0] min_sum;
        logic [ROW_W-1:0]  min_row;
        logic [OCOL_W-1:0] min_col;
    } window_extremes_t;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [EL_W-1:0]   s_element_value = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [OSUM_W-1:0] m_max_sum;
    logic [ROW_W-1:0]  m_max_row;
    logic [OCOL_W-1:0] m_max_col;
    logic [OSUM_W-1:0] m_min_sum;
    logic [ROW_W-1:0]  m_min_row;
    logic [OCOL_W-1:0] m_min_col;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [APB_AW-1:0] paddr           = '0;
    logic [APB_DW-1:0] pwdata          = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    extreme_3x3_window_sum_search_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_max_sum       (m_max_sum),
        .m_max_row       (m_max_row),
        .m_max_col       (m_max_col),
        .m_min_sum       (m_min_sum),
        .m_min_row       (m_min_row),
        .m_min_col       (m_min_col),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window-sum extreme predictor
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  cfg_rows;
    logic [FCOL_W-1:0] cfg_cols;
    logic [EL_W-1:0]   line_upper [MAX_COLS_DEF];
    logic [EL_W-1:0]   line_lower [MAX_COLS_DEF];
    logic [CSUM_W-1:0] colsum_last, colsum_older;
    logic [ROW_W-1:0]  row_pos;
    logic [OCOL_W-1:0] col_pos;
    logic [OSUM_W-1:0] top_sum, low_sum;
    logic [ROW_W-1:0]  top_row, low_row;
    logic [OCOL_W-1:0] top_col, low_col;

    window_extremes_t pending_extremes [$];
    logic [EL_W-1:0]  element_queue [$];

    int requests_queued = 0;
    int requests_taken  = 0;
    int frames_seen     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int s_idle_max      = 0;
    int r_idle_max      = 0;
    int s_gap_left      = 0;
    int m_wait          = 0;
    int m_draw;
    int stall_orders    = 0;
    int stall_served    = 0;
    int m_stall_left    = 0;
    logic s_fire        = 1'b0;
    logic m_fire        = 1'b0;

    function automatic int rows_in_use();
        return (cfg_rows < FRAME_MIN) ? FRAME_MIN : int'(cfg_rows);
    endfunction

    function automatic int cols_in_use();
        int c;
        c = (cfg_cols < FRAME_MIN) ? FRAME_MIN : int'(cfg_cols);
        return (c > MAX_COLS_DEF) ? MAX_COLS_DEF : c;
    endfunction

    function automatic void clear_trackers();
        row_pos = '0;
        col_pos = '0;
        top_sum = '0;
        low_sum = OSUM_W'(MIN_START);
        top_row = '0;
        top_col = '0;
        low_row = '0;
        low_col = '0;
    endfunction

    function automatic void apply_register(reg_index_t idx, logic [APB_DW-1:0] data);
        case (idx)
            REG_FRAME_ROWS: cfg_rows = data[ROW_W-1:0];
            REG_FRAME_COLS: cfg_cols = data[FCOL_W-1:0];
            default: ;
        endcase
        clear_trackers();
    endfunction

    function automatic void track_element(logic [EL_W-1:0] x);
        int rows, cols, r, c;
        logic [CSUM_W-1:0] colsum;
        logic [OSUM_W-1:0] win;
        window_extremes_t res;
        rows = rows_in_use();
        cols = cols_in_use();
        r = row_pos;
        c = col_pos;
        if (c >= cols) c = cols - 1;
        if (r >= rows) r = rows - 1;
        colsum = CSUM_W'(line_upper[c]) + CSUM_W'(line_lower[c]) + CSUM_W'(x);
        if (r >= 2 && c >= 2) begin
            win = OSUM_W'(colsum) + OSUM_W'(colsum_last) + OSUM_W'(colsum_older);
            if (win >= top_sum) begin
                top_sum = win;
                top_row = ROW_W'(r - 2);
                top_col = OCOL_W'(c - 2);
            end
            if (win <= low_sum) begin
                low_sum = win;
                low_row = ROW_W'(r - 2);
                low_col = OCOL_W'(c - 2);
            end
        end
        colsum_older = colsum_last;
        colsum_last  = colsum;
        line_upper[c] = line_lower[c];
        line_lower[c] = x;
        if (c + 1 < cols) begin
            col_pos = OCOL_W'(c + 1);
            row_pos = ROW_W'(r);
        end else begin
            col_pos = '0;
            if (r + 1 < rows) begin
                row_pos = ROW_W'(r + 1);
            end else begin
                res = '{top_sum, top_row, top_col, low_sum, low_row, low_col};
                pending_extremes.push_back(res);
                frames_seen++;
                clear_trackers();
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            // hold until taken
        end else if (s_gap_left != 0) begin
            s_gap_left <= s_gap_left - 1;
            s_valid    <= 1'b0;
        end else if (element_queue.size() != 0) begin
            s_valid         <= 1'b1;
            s_element_value <= element_queue.pop_front();
            s_gap_left      <= $urandom_range(0, s_idle_max);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result-side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_served != stall_orders) begin
            stall_served <= stall_orders;
            m_stall_left <= LONG_STALL;
            m_ready      <= 1'b0;
        end else if (m_stall_left != 0) begin
            m_stall_left <= m_stall_left - 1;
            m_ready      <= 1'b0;
        end else if (m_fire) begin
            m_draw = $urandom_range(0, r_idle_max);
            m_wait  <= m_draw;
            m_ready <= (m_draw == 0);
        end else if (m_wait != 0) begin
            m_wait  <= m_wait - 1;
            m_ready <= (m_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every taken request, checks every taken result
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        window_extremes_t want;
        s_fire <= aresetn && s_valid && s_ready;
        m_fire <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            track_element(s_element_value);
            requests_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_extremes.size() == 0) begin
                $error("frame result arrived with none pending");
                error_count++;
            end else begin
                want = pending_extremes.pop_front();
                check_field("max_sum", want.max_sum, m_max_sum);
                check_field("max_row", want.max_row, m_max_row);
                check_field("max_col", want.max_col, m_max_col);
                check_field("min_sum", want.min_sum, m_min_sum);
                check_field("min_row", want.min_row, m_min_row);
                check_field("min_col", want.min_col, m_min_col);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // APB and stimulus helpers
    // ------------------------------------------------------------------
    task automatic apb_transfer(input logic write, input reg_index_t idx,
                                input logic [APB_DW-1:0] data,
                                output logic [APB_DW-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_registers();
        logic [APB_DW-1:0] rd;
        apb_transfer(1'b0, REG_FRAME_ROWS, '0, rd);
        check_field("frame_rows readback", cfg_rows, rd);
        apb_transfer(1'b0, REG_FRAME_COLS, '0, rd);
        check_field("frame_cols readback", cfg_cols, rd);
    endtask

    task automatic program_frame(input logic [APB_DW-1:0] rows_data,
                                 input logic [APB_DW-1:0] cols_data);
        logic [APB_DW-1:0] rd;
        apb_transfer(1'b1, REG_FRAME_ROWS, rows_data, rd);
        apply_register(REG_FRAME_ROWS, rows_data);
        apb_transfer(1'b1, REG_FRAME_COLS, cols_data, rd);
        apply_register(REG_FRAME_COLS, cols_data);
        reg_writes += 2;
        check_registers();
    endtask

    // Queues n requests of a rows x cols frame; fewer than a full frame aborts it
    task automatic push_frame(input int rows, input int cols, input frame_fill_t fill,
                              input int n);
        int sent;
        logic [EL_W-1:0] v, level;
        sent  = 0;
        level = $urandom_range(0, 255);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (sent == n) return;
                case (fill)
                    FILL_CONST:  v = level;
                    FILL_BINARY: v = $urandom_range(0, 1) ? '1 : '0;
                    FILL_LOW:    v = $urandom_range(0, 2);
                    FILL_EDGES, FILL_EDGES_INV: begin
                        if (r < 3 && c < 3) v = '1;
                        else if (r >= rows - 3 && c >= cols - 3) v = '0;
                        else v = $urandom_range(1, 254);
                        if (fill == FILL_EDGES_INV) v = ~v;
                    end
                    default:     v = $urandom_range(0, 255);
                endcase
                element_queue.push_back(v);
                requests_queued++;
                sent++;
            end
        end
    endtask

    task automatic push_full(input frame_fill_t fill);
        push_frame(rows_in_use(), cols_in_use(), fill, rows_in_use() * cols_in_use());
    endtask

    task automatic wait_idle();
        while (requests_taken != requests_queued || pending_extremes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int rows_w, cols_w, nframes, n, frames_before, random_requests;
        frame_fill_t fill;

        cfg_rows = ROW_W'(FRAME_MIN);
        cfg_cols = FCOL_W'(FRAME_MIN);
        colsum_last  = '0;
        colsum_older = '0;
        for (int i = 0; i < MAX_COLS_DEF; i++) begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        clear_trackers();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values, full-scale and constant frames
        check_registers();
        push_full(FILL_EDGES);
        push_frame(3, 3, FILL_CONST, 9);
        wait_idle();

        // masked writes, values below the minimum
        s_idle_max = 12;
        r_idle_max = 12;
        program_frame(32'hFFFF_F000, 32'hFFFF_F802);
        push_full(FILL_RANDOM);
        push_full(FILL_BINARY);
        wait_idle();

        // ties: later window wins
        program_frame(5, 4);
        push_full(FILL_CONST);
        push_full(FILL_LOW);
        wait_idle();

        // aborted frame, restarted by a register write
        push_frame(5, 4, FILL_RANDOM, 7);
        wait_idle();
        program_frame(6, 5);
        push_full(FILL_RANDOM);
        wait_idle();

        // long output stall while requests keep coming
        s_idle_max = 0;
        r_idle_max = 0;
        program_frame(1, 1);
        stall_orders++;
        repeat (8) push_full(FILL_RANDOM);
        wait_idle();

        // random frames
        frames_before   = frames_seen;
        random_requests = 0;
        while (random_requests < RANDOM_REQUESTS || frames_seen - frames_before < RANDOM_RESULTS) begin
            s_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            r_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            nframes = $urandom_range(1, 3);
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    rows_w  = $urandom_range(0, 12);
                    cols_w  = $urandom_range(0, 24);
                    nframes = 1;
                end else begin
                    rows_w = $urandom_range(0, 8);
                    cols_w = $urandom_range(0, 12);
                end
                program_frame((32'($urandom) << ROW_W) | rows_w,
                              (32'($urandom) << FCOL_W) | cols_w);
            end
            for (int f = 0; f < nframes; f++) begin
                fill = frame_fill_t'($urandom_range(0, 5));
                if (fill >= FILL_EDGES) fill = FILL_RANDOM;
                push_full(fill);
                random_requests += rows_in_use() * cols_in_use();
            end
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, rows_in_use() * cols_in_use() - 1);
                push_frame(rows_in_use(), cols_in_use(), FILL_RANDOM, n);
                random_requests += n;
                wait_idle();
                program_frame(cfg_rows, cfg_cols);
            end
            wait_idle();
        end

        wait_idle();
        $display("Streamed %0d element requests, checked %0d frame results, %0d register writes,",
                 requests_taken, results_checked, reg_writes);
        $display("including clamped sizes, aborted frames and output backpressure.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
